// ----- rtl/core/mmstat_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block statistics package
// Widths and the types shared by the statistics core.
// ----------------------------------------------------------------------------
package mmstat_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int SAMPLE_BITS = 16;

	localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W   = SAMPLE_BITS + COUNT_W;
	localparam int MAG_W   = SUM_W - 1;
	localparam int SQ_W    = 2 * SAMPLE_BITS + COUNT_W - 2;
	localparam int VAR_W   = SQ_W + COUNT_W;
	localparam int X_W     = 2 * SAMPLE_BITS;
	localparam int RM_W    = SAMPLE_BITS + 2;
	localparam int CNT_W   = $clog2(MAG_W + 1);
	localparam int DCNT_W  = $clog2(VAR_W + 1);

	localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = 4 * SAMPLE_BITS + COUNT_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic [COUNT_W-1:0]    n;
		logic signed [SUM_W-1:0] sum;
		logic [SQ_W-1:0]       sumsq;
	} calc_in_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] mean;
		logic [SAMPLE_BITS-1:0] std_dev;
	} calc_res_t;

endpackage

// ----- rtl/core/mmstat_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, by the block sample count.
// ----------------------------------------------------------------------------
module mmstat_div
	import mmstat_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VAR_W-1:0]   dividend,
	input  logic [COUNT_W-1:0] divisor,
	output logic               done,
	output logic [VAR_W-1:0]   quot,
	output logic               rem_nz
);

	logic [VAR_W-1:0]   q_q;
	logic [COUNT_W-1:0] r_q;
	logic [COUNT_W-1:0] d_q;
	logic [DCNT_W-1:0]  cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [COUNT_W:0]   trial;
	logic [COUNT_W:0]   diff;
	logic               ge;
	logic [COUNT_W-1:0] r_next;

	always_comb begin
		trial  = {r_q, q_q[VAR_W-1]};
		diff   = trial - {1'b0, d_q};
		ge     = trial >= {1'b0, d_q};
		r_next = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(VAR_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DCNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[VAR_W-2:0], ge};
			r_q <= r_next;
		end
	end

	assign done   = done_q;
	assign quot   = q_q;
	assign rem_nz = |r_q;

endmodule

// ----- rtl/core/mmstat_calc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block end calculation
// Serial shift-add variance numerator, serial divides, two-bit square root.
// ----------------------------------------------------------------------------
module mmstat_calc
	import mmstat_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  calc_in_t  opnd,
	input  logic      ack,
	output logic      done,
	output calc_res_t res
);

	localparam logic [2:0] C_IDLE  = 3'd0;
	localparam logic [2:0] C_MULA  = 3'd1;
	localparam logic [2:0] C_MULB  = 3'd2;
	localparam logic [2:0] C_DIVM  = 3'd3;
	localparam logic [2:0] C_DIVV1 = 3'd4;
	localparam logic [2:0] C_DIVV2 = 3'd5;
	localparam logic [2:0] C_SQRT  = 3'd6;
	localparam logic [2:0] C_DONE  = 3'd7;

	logic [2:0]             state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [COUNT_W-1:0]     n_q;
	logic [COUNT_W-1:0]     nsh_q;
	logic                   neg_q;
	logic [MAG_W-1:0]       mag_q;
	logic [MAG_W-1:0]       ash_q;
	logic [VAR_W-1:0]       sq_q;
	logic [VAR_W-1:0]       p_q;
	logic                   div_go_q;
	logic [SAMPLE_BITS-1:0] mean_q;
	logic [X_W-1:0]         x_q;
	logic [SAMPLE_BITS-1:0] rt_q;
	logic [RM_W-1:0]        rm_q;

	logic [SUM_W-1:0]       sum_abs;
	logic [VAR_W-1:0]       div_dividend;
	logic                   div_done;
	logic [VAR_W-1:0]       div_quot;
	logic                   div_rem_nz;
	logic [SAMPLE_BITS-1:0] q_low;
	logic [SAMPLE_BITS-1:0] mean_next;
	logic [RM_W+1:0]        rm_sh;
	logic [RM_W+1:0]        rt_trial;
	logic [RM_W+1:0]        rm_diff;
	logic                   rt_ge;

	always_comb begin
		sum_abs   = opnd.sum[SUM_W-1] ? (SUM_W'(0) - opnd.sum) : opnd.sum;
		q_low     = div_quot[SAMPLE_BITS-1:0];
		mean_next = neg_q ? (SAMPLE_BITS'(0) - q_low - SAMPLE_BITS'(div_rem_nz)) : q_low;
		rm_sh     = {rm_q, x_q[X_W-1:X_W-2]};
		rt_trial  = {2'b00, rt_q, 2'b01};
		rm_diff   = rm_sh - rt_trial;
		rt_ge     = rm_sh >= rt_trial;
		unique case (state_q)
			C_DIVM:  div_dividend = VAR_W'(mag_q);
			C_DIVV1: div_dividend = p_q;
			default: div_dividend = div_quot;
		endcase
	end

	mmstat_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (div_dividend),
		.divisor  (n_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem_nz   (div_rem_nz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= C_IDLE;
			cnt_q    <= '0;
			div_go_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_MULA;
						cnt_q   <= CNT_W'(COUNT_W - 1);
					end
				end
				C_MULA: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= C_MULB;
						cnt_q   <= CNT_W'(MAG_W - 1);
					end
				end
				C_MULB: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q  <= C_DIVM;
						div_go_q <= 1'b1;
					end
				end
				C_DIVM: begin
					if (div_done) begin
						state_q  <= C_DIVV1;
						div_go_q <= 1'b1;
					end
				end
				C_DIVV1: begin
					if (div_done) begin
						state_q  <= C_DIVV2;
						div_go_q <= 1'b1;
					end
				end
				C_DIVV2: begin
					if (div_done) begin
						state_q <= C_SQRT;
						cnt_q   <= CNT_W'(SAMPLE_BITS - 1);
					end
				end
				C_SQRT: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= C_DONE;
					end
				end
				C_DONE: begin
					if (ack) begin
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				n_q   <= opnd.n;
				nsh_q <= opnd.n;
				neg_q <= opnd.sum[SUM_W-1];
				mag_q <= sum_abs[MAG_W-1:0];
				sq_q  <= VAR_W'(opnd.sumsq);
				p_q   <= '0;
			end
			C_MULA: begin
				if (nsh_q[0]) begin
					p_q <= p_q + sq_q;
				end
				nsh_q <= nsh_q >> 1;
				if (cnt_q == '0) begin
					sq_q  <= VAR_W'(mag_q);
					ash_q <= mag_q;
				end else begin
					sq_q <= sq_q << 1;
				end
			end
			C_MULB: begin
				if (ash_q[0]) begin
					p_q <= p_q - sq_q;
				end
				sq_q  <= sq_q << 1;
				ash_q <= ash_q >> 1;
			end
			C_DIVM: begin
				if (div_done) begin
					mean_q <= mean_next;
				end
			end
			C_DIVV2: begin
				if (div_done) begin
					x_q  <= div_quot[X_W-1:0];
					rt_q <= '0;
					rm_q <= '0;
				end
			end
			C_SQRT: begin
				x_q <= x_q << 2;
				if (rt_ge) begin
					rm_q <= rm_diff[RM_W-1:0];
					rt_q <= {rt_q[SAMPLE_BITS-2:0], 1'b1};
				end else begin
					rm_q <= rm_sh[RM_W-1:0];
					rt_q <= {rt_q[SAMPLE_BITS-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	assign done        = (state_q == C_DONE);
	assign res.mean    = mean_q;
	assign res.std_dev = rt_q;

endmodule

// ----- rtl/core/min_max_mean_stddev_stats_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block statistics top level
// Minimum, maximum, floored mean and population standard deviation of a
// block of signed Q11.4 samples, one result per block.
//
//   port group  dir  tdata bits (low to high)                        tlast
//   s_*         in   sample[15:0]                                    last
//   m_*         out  minimum, maximum, mean, std_dev, sample_count   -
//
// Samples transfer one per cycle while s_tready is high. The item that ends a
// block (tlast, or the 4096th sample) starts the end calculation: 13 multiply
// and 28 subtract steps, three divider passes and 16 root steps hold s_tready
// low, longer while the previous result is still unaccepted. The next block
// streams in while the result waits in the output register.
// arst_n clears all control state and the running count and sums.
// ----------------------------------------------------------------------------
module min_max_mean_stddev_stats_top
	import mmstat_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // sample
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // minimum, maximum, mean, std_dev, sample_count
);

	localparam logic ST_ACC  = 1'b0;
	localparam logic ST_CALC = 1'b1;

	logic                          state_q;
	logic                          calc_start_q;
	logic [COUNT_W-1:0]            count_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic signed [SUM_W-1:0]       sum_q;
	logic [SQ_W-1:0]               sumsq_q;
	logic                          m_tvalid_q;
	logic [OUT_DATA_W-1:0]         m_tdata_q;

	logic                          accept;
	logic                          first;
	logic                          blk_end;
	logic [COUNT_W-1:0]            count_inc;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic [SAMPLE_BITS-1:0]        mag;
	logic [X_W-1:0]                sq;
	logic                          take;
	logic                          calc_done;
	calc_in_t                      opnd;
	calc_res_t                     res;

	always_comb begin
		sample    = signed'(s_tdata[SAMPLE_BITS-1:0]);
		mag       = sample[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - sample) : sample;
		sq        = X_W'(mag) * X_W'(mag);
		accept    = s_tvalid && s_tready;
		first     = (count_q == '0);
		count_inc = count_q + COUNT_W'(1);
		blk_end   = s_tlast || (count_inc == COUNT_W'(MAX_SAMPLES));
		take      = (state_q == ST_CALC) && calc_done && (!m_tvalid_q || m_tready);
		opnd.n     = count_q;
		opnd.sum   = sum_q;
		opnd.sumsq = sumsq_q;
	end

	mmstat_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (calc_start_q),
		.opnd   (opnd),
		.ack    (take),
		.done   (calc_done),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_ACC;
			calc_start_q <= 1'b0;
			count_q      <= '0;
			min_q        <= '0;
			max_q        <= '0;
			sum_q        <= '0;
			sumsq_q      <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			calc_start_q <= 1'b0;
			if (take) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (accept) begin
				count_q <= count_inc;
				sum_q   <= sum_q + SUM_W'(sample);
				sumsq_q <= sumsq_q + SQ_W'(sq);
				if (first || sample < min_q) begin
					min_q <= sample;
				end
				if (first || sample > max_q) begin
					max_q <= sample;
				end
				if (blk_end) begin
					state_q      <= ST_CALC;
					calc_start_q <= 1'b1;
				end
			end else if (take) begin
				state_q <= ST_ACC;
				count_q <= '0;
				min_q   <= '0;
				max_q   <= '0;
				sum_q   <= '0;
				sumsq_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			m_tdata_q <= OUT_DATA_W'({count_q, res.std_dev, res.mean, max_q, min_q});
		end
	end

	assign s_tready = (state_q == ST_ACC);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
